>>> design/ising_metropolis_spin_update_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Ising Metropolis spin-update block
// Shorthand for clocked assertions that share the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Shared constants, payload types and helpers of the Ising Metropolis
// spin-update block.
// ----------------------------------------------------------------------------
package ism_pkg;

  // Grid and run limits.
  localparam int MAX_COLS     = 64;
  localparam int MAX_ROWS     = 64;
  localparam int MAX_ATTEMPTS = 100;

  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int SIZE_W     = 7;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int CNT_W      = 7;
  localparam int RAND_W     = 31;
  localparam int THR_W      = 32;
  localparam int NUM_THR    = 5;
  localparam int NUM_SITES  = 5;
  localparam int MIN_SIZE   = 3;

  // Configuration port.
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int REG_W   = 3;

  // Register indexes.
  localparam logic [REG_W-1:0] REG_COLS     = 3'd0;
  localparam logic [REG_W-1:0] REG_ROWS     = 3'd1;
  localparam logic [REG_W-1:0] REG_THR_M4   = 3'd2;
  localparam logic [REG_W-1:0] REG_THR_M2   = 3'd3;
  localparam logic [REG_W-1:0] REG_THR_ZERO = 3'd4;
  localparam logic [REG_W-1:0] REG_THR_P2   = 3'd5;
  localparam logic [REG_W-1:0] REG_THR_P4   = 3'd6;

  localparam logic [PDATA_W-1:0] THR_RESET = 64'h8000_0000_8000_0000;

  // Item functions; the spare code is ignored.
  localparam logic [1:0] FUNC_TRIAL = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Site slots: the addressed site and its four wrapped neighbors.
  localparam int SITE_C = 0;
  localparam int SITE_L = 1;
  localparam int SITE_R = 2;
  localparam int SITE_U = 3;
  localparam int SITE_D = 4;

  typedef struct packed {
    logic [1:0]        func;
    logic [COL_W-1:0]  col_index;
    logic [ROW_W-1:0]  row_index;
    logic [RAND_W-1:0] rand_value;
    logic              spin_write;
  } ism_req_t;

  typedef struct packed {
    logic             flipped;
    logic             run_done;
    logic [CNT_W-1:0] attempts_used;
    logic             spin_read;
    logic             coord_error;
  } ism_rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0]               cols;
    logic [SIZE_W-1:0]               rows;
    logic [NUM_THR-1:0][PDATA_W-1:0] thr;
  } ism_cfg_t;

  // An item after address decode, waiting for its grid bits.
  typedef struct packed {
    logic [1:0]                        func;
    logic [RAND_W-1:0]                 rand_value;
    logic                              spin_write;
    logic                              coord_error;
    logic [NUM_SITES-1:0][ADDR_W-1:0]  addr;
  } ism_item_t;

  // One grid write.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              value;
  } ism_wr_t;

  // Limit a size register to the legal range.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s < SIZE_W'(MIN_SIZE)) s = SIZE_W'(MIN_SIZE);
    if (s > hi) s = hi;
    return s;
  endfunction

endpackage

>>> design/ising_metropolis_spin_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin updates on a wrapped two-dimensional grid of one-bit spins.
// ----------------------------------------------------------------------------
// The block takes one item per clock. On the accepting edge the site and its
// four wrapped neighbors are looked up in five identical copies of a 4096 x 1
// grid RAM, one read port each, and the item enters the decision stage
// register; when that stage advances, the decision logic writes back any
// change to all copies and loads the output register. Only a stalled result
// side slows it: a held result word keeps the decision stage waiting, and the
// input stops once both registers are full. The write made on an edge is
// forwarded to the item read on that edge, so back-to-back items on nearby
// sites see each other's flips. The grid has no clearing pass: the user must
// write every site before it is read. Configuration is to be written only while
// the block holds no item. The block itself enforces neither rule.
module ising_metropolis_spin_update import ism_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ism_req_t           req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ism_rsp_t           rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ism_cfg_t             cfg;
  ism_item_t            item_next;
  ism_item_t            s1_item;
  logic                 s1_valid;
  logic                 s1_adv;
  logic                 req_acc;
  logic [NUM_SITES-1:0] raw;
  ism_rsp_t             rsp_next;
  ism_wr_t              wr;
  ism_wr_t              last_wr;
  logic [CNT_W-1:0]     attempt_count;
  logic [CNT_W-1:0]     attempt_next;
  logic [COL_W-1:0]     col_l;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_u;
  logic [ROW_W-1:0]     row_d;

  ism_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the decision stage moves on whenever the output register frees.
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;
  assign req_acc   = req_valid && req_ready;

  // Wrapped neighbor coordinates.
  assign col_l = (req.col_index == '0) ? COL_W'(cfg.cols - SIZE_W'(1))
                                       : req.col_index - COL_W'(1);
  assign col_r = ({1'b0, req.col_index} + SIZE_W'(1) == cfg.cols) ? '0
                                                                  : req.col_index + COL_W'(1);
  assign row_u = (req.row_index == '0) ? ROW_W'(cfg.rows - SIZE_W'(1))
                                       : req.row_index - ROW_W'(1);
  assign row_d = ({1'b0, req.row_index} + SIZE_W'(1) == cfg.rows) ? '0
                                                                  : req.row_index + ROW_W'(1);

  // Decode the incoming item.
  always_comb begin
    item_next.func        = req.func;
    item_next.rand_value  = req.rand_value;
    item_next.spin_write  = req.spin_write;
    item_next.coord_error = (req.func != FUNC_SPARE) &&
                            (({1'b0, req.col_index} >= cfg.cols) ||
                             ({1'b0, req.row_index} >= cfg.rows));
    item_next.addr[SITE_C] = {req.row_index, req.col_index};
    item_next.addr[SITE_L] = {req.row_index, col_l};
    item_next.addr[SITE_R] = {req.row_index, col_r};
    item_next.addr[SITE_U] = {row_u, req.col_index};
    item_next.addr[SITE_D] = {row_d, req.col_index};
  end

  // Grid copies, one per site slot, all written alike.
  for (genvar k = 0; k < NUM_SITES; k++) begin : g_grid
    ism_ram #(
      .WIDTH (1),
      .DEPTH (GRID_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (s1_adv && wr.en),
      .waddr (wr.addr),
      .wdata (wr.value),
      .re    (req_acc),
      .raddr (item_next.addr[k]),
      .rdata (raw[k])
    );
  end

  // Decision stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_item <= item_next;
    end
  end

  ism_trial u_trial (
    .item          (s1_item),
    .raw           (raw),
    .last_wr       (last_wr),
    .thr           (cfg.thr),
    .attempt_count (attempt_count),
    .rsp           (rsp_next),
    .wr            (wr),
    .attempt_next  (attempt_next)
  );

  // Run counter and the most recent grid write.
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_count <= '0;
      last_wr       <= '0;
    end else if (s1_adv) begin
      attempt_count <= attempt_next;
      if (wr.en) begin
        last_wr <= wr;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> design/ism_ram.sv
// ----------------------------------------------------------------------------
// ism_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ism_regs.sv
// ----------------------------------------------------------------------------
// ism_regs
// Configuration registers: grid sizes and the five acceptance threshold
// pairs, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module ism_regs import ism_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ism_cfg_t           cfg
);

  logic             wr_en;
  logic [REG_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_W];

  // Register writes; sizes are clamped to the legal range as they land.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols <= SIZE_W'(MAX_COLS);
      cfg.rows <= SIZE_W'(MAX_ROWS);
      for (int k = 0; k < NUM_THR; k++) begin
        cfg.thr[k] <= THR_RESET;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COLS:     cfg.cols   <= clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_COLS));
        REG_ROWS:     cfg.rows   <= clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_ROWS));
        REG_THR_M4:   cfg.thr[0] <= pwdata;
        REG_THR_M2:   cfg.thr[1] <= pwdata;
        REG_THR_ZERO: cfg.thr[2] <= pwdata;
        REG_THR_P2:   cfg.thr[3] <= pwdata;
        REG_THR_P4:   cfg.thr[4] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_COLS:     prdata = PDATA_W'(cfg.cols);
      REG_ROWS:     prdata = PDATA_W'(cfg.rows);
      REG_THR_M4:   prdata = cfg.thr[0];
      REG_THR_M2:   prdata = cfg.thr[1];
      REG_THR_ZERO: prdata = cfg.thr[2];
      REG_THR_P2:   prdata = cfg.thr[3];
      REG_THR_P4:   prdata = cfg.thr[4];
      default:      prdata = '0;
    endcase
  end

endmodule

>>> design/ism_trial.sv
// ----------------------------------------------------------------------------
// ism_trial
// Decision logic of one item: forwards the latest grid write into the five
// site bits, runs the Metropolis test and forms the result and write-back.
// ----------------------------------------------------------------------------
module ism_trial import ism_pkg::*; (
  input  ism_item_t                       item,
  input  logic [NUM_SITES-1:0]            raw,
  input  ism_wr_t                         last_wr,
  input  logic [NUM_THR-1:0][PDATA_W-1:0] thr,
  input  logic [CNT_W-1:0]                attempt_count,
  output ism_rsp_t                        rsp,
  output ism_wr_t                         wr,
  output logic [CNT_W-1:0]                attempt_next
);

  logic [NUM_SITES-1:0] site;
  logic                 s;
  logic [2:0]           ups;
  logic [2:0]           sel;
  logic [PDATA_W-1:0]   thr_pair;
  logic [THR_W-1:0]     thr_val;
  logic                 accept;
  logic [CNT_W-1:0]     count;
  logic                 limit;

  // The RAM read may have missed a write made on the same edge.
  always_comb begin
    for (int k = 0; k < NUM_SITES; k++) begin
      site[k] = (last_wr.en && (last_wr.addr == item.addr[k])) ? last_wr.value : raw[k];
    end
  end

  assign s   = site[SITE_C];
  assign ups = 3'(site[SITE_L]) + 3'(site[SITE_R]) + 3'(site[SITE_U]) + 3'(site[SITE_D]);

  // Threshold slot is (m + 4) / 2, which is the up-neighbor count for an up
  // spin and its complement to four for a down spin.
  assign sel = s ? ups : (3'd4 - ups);

  always_comb begin
    unique case (sel)
      3'd0:    thr_pair = thr[0];
      3'd1:    thr_pair = thr[1];
      3'd2:    thr_pair = thr[2];
      3'd3:    thr_pair = thr[3];
      3'd4:    thr_pair = thr[4];
      default: thr_pair = thr[2];
    endcase
  end

  assign thr_val = s ? thr_pair[THR_W-1:0] : thr_pair[PDATA_W-1:THR_W];
  assign accept  = {1'b0, item.rand_value} < thr_val;
  assign count   = attempt_count + CNT_W'(1);
  assign limit   = count >= CNT_W'(MAX_ATTEMPTS);

  // Result, write-back and run counter per function.
  always_comb begin
    rsp          = '0;
    wr.en        = 1'b0;
    wr.addr      = item.addr[SITE_C];
    wr.value     = item.spin_write;
    attempt_next = attempt_count;
    if (item.coord_error) begin
      rsp.coord_error = 1'b1;
    end else begin
      unique case (item.func)
        FUNC_TRIAL: begin
          rsp.flipped       = accept;
          rsp.run_done      = accept || limit;
          rsp.attempts_used = count;
          rsp.spin_read     = s ^ accept;
          wr.en             = accept;
          wr.value          = ~s;
          attempt_next      = (accept || limit) ? '0 : count;
        end
        FUNC_WRITE: begin
          rsp.spin_read = item.spin_write;
          wr.en         = 1'b1;
        end
        FUNC_READ: begin
          rsp.spin_read = s;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/ism_checker.sv
// ----------------------------------------------------------------------------
// ism_checker
// Port-level checks of the spin-update block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ising_metropolis_spin_update_macros.svh"

module ism_checker import ism_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input ism_rsp_t rsp
);

  // A word held back by the consumer stays as it is.
  `ISM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

  // An ignored item reports nothing but the coordinate error.
  `ISM_ASSERT_NOW(a_err_clean, rsp_valid && rsp.coord_error, !rsp.flipped && !rsp.run_done && (rsp.attempts_used == '0) && !rsp.spin_read, "coordinate error with other fields set")

  // A flip always ends the run.
  `ISM_ASSERT_NOW(a_flip_done, rsp_valid && rsp.flipped, rsp.run_done && (rsp.attempts_used != '0), "flip without run end")

  // A run that ends without a flip has used every attempt.
  `ISM_ASSERT_NOW(a_limit, rsp_valid && rsp.run_done && !rsp.flipped, rsp.attempts_used == CNT_W'(MAX_ATTEMPTS), "run ended early without a flip")

endmodule

bind ising_metropolis_spin_update ism_checker u_ism_checker (.*);

>>> tb/ising_metropolis_spin_update_checker.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_checker
// Watches the request, result and register ports of the spin-update block,
// predicts every result word from its own copy of the grid, the attempt
// counter and the registers, and compares each result field by field.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_checker
  import ism_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  ism_req_t           req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  ism_rsp_t           rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_results,
  output int                 cols_now,
  output int                 rows_now,
  output int                 flip_count,
  output int                 limit_run_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Keeps a broken block from flooding the log.
  localparam int MAX_REPORTS = 200;

  bit                 spins [MAX_ROWS][MAX_COLS];
  int unsigned        attempt_run;
  logic [PDATA_W-1:0] thr_regs [NUM_THR];
  ism_rsp_t           predicted_results [$];
  ism_rsp_t           oldest;

  function automatic int spin_sign(input bit up);
    return up ? 1 : -1;
  endfunction

  // A size register keeps its low seven bits, limited to 3..top_size.
  function automatic int clamp_grid_size(input logic [PDATA_W-1:0] word, input int top_size);
    int sz;
    sz = int'(word[SIZE_W-1:0]);
    if (sz < MIN_SIZE) sz = MIN_SIZE;
    if (sz > top_size) sz = top_size;
    return sz;
  endfunction

  // Applies one request word to the grid copy and returns its result word.
  function automatic ism_rsp_t predict_site_update(input ism_req_t it);
    ism_rsp_t    res;
    int          col;
    int          row;
    int          cl;
    int          cr;
    int          ru;
    int          rd;
    int          s;
    int          m;
    int          nsum;
    logic [THR_W-1:0] limit;
    int unsigned next_count;
    res = '0;
    col = int'(it.col_index);
    row = int'(it.row_index);
    if (it.func != FUNC_TRIAL && it.func != FUNC_WRITE && it.func != FUNC_READ) return res;
    // Off-grid sites change nothing and only raise the error flag.
    if (col >= cols_now || row >= rows_now) begin
      res.coord_error = 1'b1;
      return res;
    end
    if (it.func == FUNC_WRITE) begin
      spins[row][col] = it.spin_write;
    end else if (it.func == FUNC_TRIAL) begin
      cl = (col == 0) ? cols_now - 1 : col - 1;
      cr = (col + 1 == cols_now) ? 0 : col + 1;
      ru = (row == 0) ? rows_now - 1 : row - 1;
      rd = (row + 1 == rows_now) ? 0 : row + 1;
      s = spin_sign(spins[row][col]);
      nsum = spin_sign(spins[row][cl]) + spin_sign(spins[row][cr]) +
             spin_sign(spins[ru][col]) + spin_sign(spins[rd][col]);
      m = s * nsum;
      // Low half of the register serves an up spin, high half a down spin.
      limit = (s > 0) ? thr_regs[(m + 4) / 2][THR_W-1:0]
                      : thr_regs[(m + 4) / 2][PDATA_W-1:THR_W];
      next_count = attempt_run + 1;
      if ({1'b0, it.rand_value} < limit) begin
        spins[row][col] = ~spins[row][col];
        res.flipped = 1'b1;
        flip_count++;
      end
      res.attempts_used = CNT_W'(next_count);
      if (res.flipped || next_count >= MAX_ATTEMPTS) begin
        res.run_done = 1'b1;
        attempt_run = 0;
        if (!res.flipped) limit_run_count++;
      end else begin
        attempt_run = next_count;
      end
    end
    res.spin_read = spins[row][col];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      predicted_results.delete();
      attempt_run = 0;
      cols_now = MAX_COLS;
      rows_now = MAX_ROWS;
      for (int k = 0; k < NUM_THR; k++) thr_regs[k] = THR_RESET;
      fail_count = 0;
      flip_count = 0;
      limit_run_count = 0;
    end else begin
      // Register writes land at the access edge.
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:3])
          REG_COLS: cols_now = clamp_grid_size(pwdata, MAX_COLS);
          REG_ROWS: rows_now = clamp_grid_size(pwdata, MAX_ROWS);
          REG_THR_M4, REG_THR_M2, REG_THR_ZERO, REG_THR_P2, REG_THR_P4: begin
            thr_regs[int'(paddr[PADDR_W-1:3] - REG_THR_M4)] = pwdata;
          end
          default: ;
        endcase
      end

      // A result word always belongs to a request word accepted earlier.
      if (rsp_valid && rsp_ready) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word %p arrived with nothing outstanding", $time, rsp);
        end else begin
          oldest = predicted_results.pop_front();
          check_field("flipped", oldest.flipped, rsp.flipped);
          check_field("run_done", oldest.run_done, rsp.run_done);
          check_field("attempts_used", oldest.attempts_used, rsp.attempts_used);
          check_field("spin_read", oldest.spin_read, rsp.spin_read);
          check_field("coord_error", oldest.coord_error, rsp.coord_error);
        end
      end

      // Predict each accepted request word in arrival order.
      if (req_valid && req_ready) predicted_results.push_back(predict_site_update(req));
      pending_results = predicted_results.size();
    end
  end

endmodule

>>> tb/ising_metropolis_spin_update_tb.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_tb
// Drives trial, write and read words into the spin-update block under several
// grid sizes and threshold sets, with bursty requests and a stalling result
// side; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ism_pkg::*;

  localparam int LONG_STALL      = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int TAIL_CYCLES     = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  ism_req_t           req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ism_rsp_t           rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending_results;
  int eff_cols;
  int eff_rows;
  int flip_count;
  int limit_run_count;

  // Stimulus bookkeeping.
  bit       site_loaded [MAX_ROWS][MAX_COLS];
  bit       gaps_on = 1'b1;
  int       burst_left = 0;
  logic     hold_off_req = 1'b0;
  logic     hold_off_done = 1'b0;
  int       stall_left = 0;
  int       ready_cycle = 0;
  int       idle_cycles = 0;
  int       trial_items = 0;
  int       read_items = 0;
  int       write_items = 0;
  int       off_grid_items = 0;
  int       spare_items = 0;
  int       config_count = 0;
  int       sent_items = 0;
  int       phase_start = 0;
  ism_cfg_t cfg;
  int       sel;
  int       col;
  int       row;
  int       theme;
  logic [1:0]        fn;
  logic [RAND_W-1:0] rnd;

  ising_metropolis_spin_update i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ising_metropolis_spin_update_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .cols_now        (eff_cols),
    .rows_now        (eff_rows),
    .flip_count      (flip_count),
    .limit_run_count (limit_run_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: one long hold-off on request, otherwise one of four ready
  // patterns in turn, picked from the cycle count.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (stall_left != 0) begin
        rsp_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (hold_off_req && !hold_off_done) begin
        rsp_ready <= 1'b0;
        stall_left <= LONG_STALL;
        hold_off_done <= 1'b1;
      end else begin
        case ((ready_cycle / 256) % 4)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ready <= ($urandom_range(0, 9) < 3);
          default: rsp_ready <= ((ready_cycle % 5) < 3);
        endcase
      end
    end
  end

  // Ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offers one request word and holds it until accepted; bursts may end in a random gap while gaps are on.
  task automatic offer(input ism_req_t it);
    int gap;
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Sends one item; any site it would read that was never loaded gets a
  // write word first, so the grid is never read where it holds nothing.
  task automatic issue(input logic [1:0] func, input int c, input int r,
                       input logic [RAND_W-1:0] rv, input logic sw);
    ism_req_t it;
    int       site_c [NUM_SITES];
    int       site_r [NUM_SITES];
    int       n_sites;
    bit       in_grid;
    in_grid = (c < eff_cols) && (r < eff_rows);
    n_sites = 0;
    if (in_grid && func == FUNC_READ) n_sites = 1;
    if (in_grid && func == FUNC_TRIAL) n_sites = NUM_SITES;
    site_c[SITE_C] = c;
    site_r[SITE_C] = r;
    site_c[SITE_L] = (c == 0) ? eff_cols - 1 : c - 1;
    site_r[SITE_L] = r;
    site_c[SITE_R] = (c + 1 == eff_cols) ? 0 : c + 1;
    site_r[SITE_R] = r;
    site_c[SITE_U] = c;
    site_r[SITE_U] = (r == 0) ? eff_rows - 1 : r - 1;
    site_c[SITE_D] = c;
    site_r[SITE_D] = (r + 1 == eff_rows) ? 0 : r + 1;
    for (int k = 0; k < n_sites; k++) begin
      if (!site_loaded[site_r[k]][site_c[k]]) begin
        it.func = FUNC_WRITE;
        it.col_index = COL_W'(site_c[k]);
        it.row_index = ROW_W'(site_r[k]);
        it.rand_value = RAND_W'($urandom);
        it.spin_write = 1'($urandom_range(0, 1));
        site_loaded[site_r[k]][site_c[k]] = 1'b1;
        write_items++;
        offer(it);
      end
    end
    it.func = func;
    it.col_index = COL_W'(c);
    it.row_index = ROW_W'(r);
    it.rand_value = rv;
    it.spin_write = sw;
    if (func == FUNC_SPARE) spare_items++;
    else if (!in_grid) off_grid_items++;
    else if (func == FUNC_TRIAL) trial_items++;
    else if (func == FUNC_READ) read_items++;
    else begin
      write_items++;
      site_loaded[r][c] = 1'b1;
    end
    offer(it);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then the bus goes idle.
  task automatic write_register(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all seven registers; size words carry random upper bits.
  task automatic apply_config(input ism_cfg_t setting);
    logic [PDATA_W-1:0] word;
    word = {$urandom, $urandom};
    word[SIZE_W-1:0] = setting.cols;
    write_register(REG_COLS, word);
    word = {$urandom, $urandom};
    word[SIZE_W-1:0] = setting.rows;
    write_register(REG_ROWS, word);
    for (int k = 0; k < NUM_THR; k++) write_register(REG_THR_M4 + REG_W'(k), setting.thr[k]);
    config_count++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SIZE_W'($urandom_range(0, 2));
    if (pick == 1) return SIZE_W'($urandom_range(9, 20));
    return SIZE_W'($urandom_range(3, 8));
  endfunction

  // One threshold half drawn from the interesting corners and the middle.
  function automatic logic [THR_W-1:0] pick_half();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'h8000_0000;
      2: return '1;
      3: return $urandom;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full 64 x 64 torus, every trial accepted.
    issue(FUNC_TRIAL, 0, 0, '1, 1'b0);
    issue(FUNC_TRIAL, 63, 63, '0, 1'b1);
    issue(FUNC_TRIAL, 63, 0, RAND_W'($urandom), 1'b0);
    issue(FUNC_WRITE, 31, 32, '1, 1'b1);
    issue(FUNC_READ, 31, 32, '0, 1'b0);
    issue(FUNC_WRITE, 31, 32, '0, 1'b0);
    issue(FUNC_READ, 31, 32, '1, 1'b1);
    issue(FUNC_SPARE, 63, 63, '1, 1'b1);
    issue(FUNC_SPARE, 0, 0, '0, 1'b0);
    issue(FUNC_READ, 63, 63, '0, 1'b0);
    drain_results();

    // Sizes below the minimum clamp to 3 x 3; a threshold right at 2^30
    // separates accept from reject by one count.
    cfg.cols = '0;
    cfg.rows = SIZE_W'(2);
    for (int k = 0; k < NUM_THR; k++) cfg.thr[k] = 64'h4000_0000_4000_0000;
    apply_config(cfg);
    issue(FUNC_TRIAL, 1, 1, 31'h3FFF_FFFF, 1'b0);
    issue(FUNC_TRIAL, 1, 1, 31'h4000_0000, 1'b0);
    issue(FUNC_TRIAL, 2, 2, '0, 1'b1);
    issue(FUNC_TRIAL, 0, 0, '1, 1'b0);
    issue(FUNC_TRIAL, 3, 0, '0, 1'b1);
    issue(FUNC_WRITE, 0, 3, '1, 1'b1);
    issue(FUNC_READ, 63, 63, '1, 1'b0);
    issue(FUNC_TRIAL, 2, 3, '0, 1'b0);
    issue(FUNC_READ, 2, 2, '0, 1'b0);
    drain_results();

    // Random phases, each under its own grid size and threshold set.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          cfg.cols = SIZE_W'(64);
          cfg.rows = SIZE_W'(100);
        end
        5: begin
          cfg.cols = SIZE_W'(3);
          cfg.rows = SIZE_W'(64);
        end
        8: begin
          cfg.cols = SIZE_W'(127);
          cfg.rows = SIZE_W'(3);
        end
        default: begin
          cfg.cols = pick_size();
          cfg.rows = pick_size();
        end
      endcase
      theme = phase % 5;
      for (int k = 0; k < NUM_THR; k++) begin
        case (theme)
          0: cfg.thr[k] = {THR_W'($urandom_range(0, 32'h8000_0000)),
                           THR_W'($urandom_range(0, 32'h8000_0000))};
          1: cfg.thr[k] = '0;
          2: cfg.thr[k] = '1;
          // Energy-lowering or neutral flips always pass; costly ones rarely.
          3: cfg.thr[k] = (k <= 2) ? THR_RESET :
                          {THR_W'($urandom_range(0, 32'h3000_0000) >> (k - 2)),
                           THR_W'($urandom_range(0, 32'h3000_0000) >> (k - 2))};
          default: cfg.thr[k] = {pick_half(), pick_half()};
        endcase
      end
      apply_config(cfg);
      gaps_on = (phase % 4 != 0) && (phase != 2);

      // Each phase sends its share of words, loading writes included.
      phase_start = sent_items;
      for (int n = 0; sent_items - phase_start < ITEMS_PER_PHASE; n++) begin
        // Stall the result side while requests keep coming.
        if (phase == 2 && n == 20) hold_off_req <= 1'b1;
        sel = $urandom_range(0, 99);
        rnd = RAND_W'($urandom);
        case ($urandom_range(0, 9))
          0: rnd = '0;
          1: rnd = '1;
          default: ;
        endcase
        if (sel >= 96) begin
          issue(FUNC_SPARE, $urandom_range(0, 63), $urandom_range(0, 63), rnd,
                1'($urandom_range(0, 1)));
        end else if (sel >= 86 && (eff_cols < MAX_COLS || eff_rows < MAX_ROWS)) begin
          do begin
            col = $urandom_range(0, 63);
            row = $urandom_range(0, 63);
          end while (col < eff_cols && row < eff_rows);
          case ($urandom_range(0, 2))
            0: fn = FUNC_TRIAL;
            1: fn = FUNC_WRITE;
            default: fn = FUNC_READ;
          endcase
          issue(fn, col, row, rnd, 1'($urandom_range(0, 1)));
        end else begin
          // Half the sites fall in a small corner window so flips interact.
          if ($urandom_range(0, 1) == 0) begin
            col = $urandom_range(0, eff_cols - 1);
            row = $urandom_range(0, eff_rows - 1);
          end else begin
            col = $urandom_range(0, ((eff_cols < 6) ? eff_cols : 6) - 1);
            row = $urandom_range(0, ((eff_rows < 6) ? eff_rows : 6) - 1);
          end
          if (sel < 58 || sel >= 86) fn = FUNC_TRIAL;
          else if (sel < 72) fn = FUNC_READ;
          else fn = FUNC_WRITE;
          issue(fn, col, row, rnd, 1'($urandom_range(0, 1)));
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d trials, %0d reads, %0d writes, %0d off-grid and %0d unused-code words.",
             trial_items, read_items, write_items, off_grid_items, spare_items);
    $display("%0d trials flipped a spin and %0d runs hit the attempt limit over %0d settings.",
             flip_count, limit_run_count, config_count + 1);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/ism_pkg.sv
design/ism_ram.sv
design/ism_regs.sv
design/ism_trial.sv
design/ising_metropolis_spin_update.sv
design/ism_checker.sv
tb/ising_metropolis_spin_update_checker.sv
tb/ising_metropolis_spin_update_tb.sv
